// ----- hdl/ole_pkg.sv -----
// Package for the ordered list engine: field widths, codes and transaction types.
package ole_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_ERASE_POS = 3'd1,
    CMD_ERASE_VAL = 3'd2,
    CMD_FIND      = 3'd3,
    CMD_READ      = 3'd4,
    CMD_MODIFY    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    status_t                   status;
    logic [INDEX_W-1:0]        found_index;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        entry_count;
  } result_t;

endpackage

// ----- hdl/ordered_list_engine.sv -----
// Top level of the ordered list engine: command decode, walk sequencer and result register.
//
//   channel   direction  handshake                  payload
//   request   in         start & !busy              ole_pkg::request_t
//   result    out        done, one cycle, no stall  ole_pkg::result_t
//
// A transaction that fails its checks, or that writes one entry with no shift, skips the
// walk and goes straight to the finish state. Shift, search, compaction and read walk n
// entries through the single RAM read port, one per cycle (n up to CAPACITY - 1 for a
// shift, up to CAPACITY for a search). The result strobe is high in the first cycle with
// busy low. Reset clears state, count and flags; the entry RAM is not cleared.
module ordered_list_engine #(
  parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ole_pkg::request_t request,
  output logic              done,
  output ole_pkg::result_t  result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;

  ole_pkg::state_t  state, state_next;
  logic [CW-1:0]    count, count_next;
  ole_pkg::cmd_t    op, op_next;
  logic [AW-1:0]    pos_r, pos_next;
  logic [DATA_WIDTH-1:0] val_r, val_next;
  ole_pkg::status_t status_r, status_next;
  logic             rd_on, rd_on_next;
  logic [AW-1:0]    rd_idx, rd_idx_next;
  logic [AW-1:0]    rd_end, rd_end_next;
  logic             rd_up, rd_up_next;
  logic             pend, pend_next;
  logic [AW-1:0]    pend_idx, pend_idx_next;
  logic [CW-1:0]    j, j_next;
  logic             hit, hit_next;
  logic [AW-1:0]    fidx, fidx_next;
  logic [DATA_WIDTH-1:0] rval, rval_next;
  logic             done_next;
  ole_pkg::result_t result_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  ole_pkg::status_t st_pre;
  logic             walk_pre;
  logic [AW-1:0]    start_pre, end_pre;
  logic             up_pre;
  logic [PW-1:0]    pos_x, cnt_x;
  logic             full;

  ole_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  assign busy = (state != ole_pkg::S_IDLE);

  // decode and check the incoming transaction
  always_comb begin
    pos_x     = PW'(request.pos);
    cnt_x     = PW'(count);
    full      = (count == CW'(CAPACITY));
    st_pre    = ole_pkg::ST_OK;
    walk_pre  = 1'b0;
    start_pre = '0;
    end_pre   = AW'(count - CW'(1));
    up_pre    = 1'b1;
    unique case (request.cmd)
      ole_pkg::CMD_INSERT: begin
        if (full) begin
          st_pre = ole_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          st_pre = ole_pkg::ST_BADPOS;
        end else begin
          walk_pre  = (pos_x != cnt_x);
          start_pre = AW'(count - CW'(1));
          end_pre   = AW'(request.pos);
          up_pre    = 1'b0;
        end
      end
      ole_pkg::CMD_ERASE_POS: begin
        if (count == '0) begin
          st_pre = ole_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st_pre = ole_pkg::ST_BADPOS;
        end else begin
          walk_pre  = ((pos_x + PW'(1)) < cnt_x);
          start_pre = AW'(pos_x + PW'(1));
        end
      end
      ole_pkg::CMD_ERASE_VAL: begin
        if (count == '0) begin
          st_pre = ole_pkg::ST_EMPTY;
        end else begin
          walk_pre = 1'b1;
        end
      end
      ole_pkg::CMD_FIND: begin
        if (count == '0) begin
          st_pre = ole_pkg::ST_NOTFOUND;
        end else begin
          walk_pre = 1'b1;
        end
      end
      ole_pkg::CMD_READ: begin
        if (pos_x >= cnt_x) begin
          st_pre = ole_pkg::ST_BADPOS;
        end else begin
          walk_pre  = 1'b1;
          start_pre = AW'(request.pos);
          end_pre   = AW'(request.pos);
        end
      end
      ole_pkg::CMD_MODIFY: begin
        if (pos_x >= cnt_x) begin
          st_pre = ole_pkg::ST_BADPOS;
        end
      end
      default: begin
        st_pre = ole_pkg::ST_BADPOS;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ole_pkg::S_IDLE: begin
        if (start) begin
          state_next = walk_pre ? ole_pkg::S_WALK : ole_pkg::S_FINISH;
        end
      end
      ole_pkg::S_WALK: begin
        if (!rd_on && !pend) begin
          state_next = ole_pkg::S_FINISH;
        end
      end
      ole_pkg::S_FINISH: begin
        state_next = ole_pkg::S_IDLE;
      end
      default: begin
        state_next = ole_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_next    = count;
    op_next       = op;
    pos_next      = pos_r;
    val_next      = val_r;
    status_next   = status_r;
    rd_on_next    = rd_on;
    rd_idx_next   = rd_idx;
    rd_end_next   = rd_end;
    rd_up_next    = rd_up;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    j_next        = j;
    hit_next      = hit;
    fidx_next     = fidx;
    rval_next     = rval;
    done_next     = 1'b0;
    result_next   = result;
    we            = 1'b0;
    waddr         = pend_idx;
    wdata         = rdata;
    unique case (state)
      ole_pkg::S_IDLE: begin
        if (start) begin
          op_next       = request.cmd;
          pos_next      = AW'(request.pos);
          val_next      = DATA_WIDTH'($unsigned(request.value));
          status_next   = st_pre;
          rd_on_next    = walk_pre;
          rd_idx_next   = start_pre;
          rd_end_next   = end_pre;
          rd_up_next    = up_pre;
          pend_next     = 1'b0;
          j_next        = '0;
          hit_next      = 1'b0;
          fidx_next     = '0;
          rval_next     = '0;
        end
      end
      ole_pkg::S_WALK: begin
        // advance the read pointer
        pend_next     = rd_on;
        pend_idx_next = rd_idx;
        if (rd_on) begin
          if (rd_idx == rd_end) begin
            rd_on_next = 1'b0;
          end else begin
            rd_idx_next = rd_up ? (rd_idx + AW'(1)) : (rd_idx - AW'(1));
          end
        end
        // consume the entry read last cycle
        if (pend) begin
          case (op)
            ole_pkg::CMD_INSERT: begin
              we    = 1'b1;
              waddr = pend_idx + AW'(1);
            end
            ole_pkg::CMD_ERASE_POS: begin
              we    = 1'b1;
              waddr = pend_idx - AW'(1);
            end
            ole_pkg::CMD_ERASE_VAL: begin
              if (rdata != val_r) begin
                we     = 1'b1;
                waddr  = AW'(j);
                j_next = j + CW'(1);
              end else begin
                hit_next = 1'b1;
              end
            end
            ole_pkg::CMD_FIND: begin
              if ((rdata == val_r) && !hit) begin
                hit_next  = 1'b1;
                fidx_next = pend_idx;
              end
            end
            ole_pkg::CMD_READ: begin
              rval_next = rdata;
            end
            default: begin
            end
          endcase
        end
      end
      ole_pkg::S_FINISH: begin
        done_next = 1'b1;
        if (status_r == ole_pkg::ST_OK) begin
          case (op)
            ole_pkg::CMD_INSERT: begin
              we         = 1'b1;
              waddr      = pos_r;
              wdata      = val_r;
              count_next = count + CW'(1);
            end
            ole_pkg::CMD_ERASE_POS: begin
              count_next = count - CW'(1);
            end
            ole_pkg::CMD_ERASE_VAL: begin
              if (hit) begin
                count_next = j;
              end else begin
                status_next = ole_pkg::ST_NOTFOUND;
              end
            end
            ole_pkg::CMD_FIND: begin
              if (!hit) begin
                status_next = ole_pkg::ST_NOTFOUND;
              end
            end
            ole_pkg::CMD_MODIFY: begin
              we    = 1'b1;
              waddr = pos_r;
              wdata = val_r;
            end
            default: begin
            end
          endcase
        end
        result_next.status      = status_next;
        result_next.found_index = ole_pkg::INDEX_W'(fidx);
        result_next.read_value  = ole_pkg::VALUE_W'(rval);
        result_next.entry_count = ole_pkg::COUNT_W'(count_next);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::S_IDLE;
      count <= '0;
      rd_on <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rd_on <= rd_on_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    pos_r    <= pos_next;
    val_r    <= val_next;
    status_r <= status_next;
    rd_idx   <= rd_idx_next;
    rd_end   <= rd_end_next;
    rd_up    <= rd_up_next;
    pend_idx <= pend_idx_next;
    j        <= j_next;
    hit      <= hit_next;
    fidx     <= fidx_next;
    rval     <= rval_next;
    result   <= result_next;
  end

endmodule

// ----- hdl/ole_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
